@@ sv/fds_pkg.sv @@
// ---------------------------------------------------------------------------
// fds_pkg
// Shared types and constants for the FAT16 directory entry scanner.
// ---------------------------------------------------------------------------
package fds_pkg;

    localparam int NAME_LEN        = 11;
    localparam int BASE_LEN        = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  ATTR_LONG    = 8'h0F;
    localparam logic [7:0]  MARK_DELETED = 8'hE5;
    localparam logic [7:0]  MARK_END     = 8'h00;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_DOT     = 8'h2E;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [15:0] END_CLUSTER  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam logic STATUS_CHAR = 1'b0;
    localparam logic STATUS_END  = 1'b1;

    typedef logic [NAME_LEN-1:0][7:0] name_chars_t;

    // One directory entry request.
    typedef struct packed {
        logic        start_scan;
        logic [7:0]  wanted_index;
        logic [63:0] name_bytes;
        logic [23:0] ext_bytes;
        logic [7:0]  entry_attributes;
        logic [15:0] entry_first_cluster;
        logic [31:0] entry_size;
    } scan_in_t;

    // One result item.
    typedef struct packed {
        logic        status;
        logic [7:0]  name_char;
        logic [7:0]  found_attributes;
        logic [31:0] found_size;
        logic [15:0] found_cluster;
        logic        last;
    } scan_out_t;

    // Work handed from the classifier to the name emitter.
    typedef struct packed {
        logic        is_end;
        name_chars_t chars;
        logic [7:0]  attributes;
        logic [31:0] size;
        logic [15:0] cluster;
    } job_t;

endpackage

@@ sv/fat_dir_entry_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// fat_dir_entry_scanner_unit
// FAT16 directory scanner: finds the Nth valid short entry and streams its
// formatted 8.3 name, or reports end of directory.
// ---------------------------------------------------------------------------
//
//  channel  signals                            payload     role
//  -------  ---------------------------------  ----------  --------------------
//  entry    entry_valid/entry_ready/entry_data scan_in_t   one directory entry
//  result   result_valid/result_ready/...data  scan_out_t  one name character
//
//  Skipped, counted or ignored entries push no job; a new entry is taken
//  every cycle while the job queue has room. A matched entry is loaded
//  into the emitter, which gives a result per non-space name byte, a dot
//  if extension byte 0 is not a space, and a NUL terminator, one per cycle
//  unless result_ready stalls it; an end-of-directory entry gives one end
//  result. Reset clears the entry counter, done flag, queue and output
//  valid flag. Stalls: result_ready low holds the output register and the
//  emitter; entries keep flowing until the queue (QUEUE_DEPTH jobs) fills.
// ---------------------------------------------------------------------------
module fat_dir_entry_scanner_unit #(
    parameter int QUEUE_DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               entry_valid,
    output logic               entry_ready,
    input  fds_pkg::scan_in_t  entry_data,
    output logic               result_valid,
    input  logic               result_ready,
    output fds_pkg::scan_out_t result_data
);
    import fds_pkg::*;

    logic  accept;
    logic  push;
    job_t  push_job;
    logic  full;
    logic  pop;
    logic  head_valid;
    job_t  head_job;

    // Accept whenever the queue is not full; skipped entries also wait while
    // it is full.
    assign entry_ready = !full;
    assign accept      = entry_valid && entry_ready;

    // Classify entries and hold the search state.
    fds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .entry    (entry_data),
        .push     (push),
        .push_job (push_job)
    );

    // Decouple classification from name emission.
    fds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Stream the name run through the output register.
    fds_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (head_valid),
        .job          (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

@@ sv/fds_front.sv @@
// ---------------------------------------------------------------------------
// fds_front
// Classify entries: skip, count, match, end of directory or ignore once done.
// ---------------------------------------------------------------------------
module fds_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  fds_pkg::scan_in_t entry,
    output logic             push,
    output fds_pkg::job_t    push_job
);
    import fds_pkg::*;

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        done_reg;
    logic        done_next;

    logic [15:0] count_eff;
    logic        done_eff;
    logic [7:0]  first_byte;
    logic        is_end;
    logic        is_skip;
    logic        is_match;

    always_comb
    begin
        count_eff  = entry.start_scan ? 16'd0 : count_reg;
        done_eff   = entry.start_scan ? 1'b0 : done_reg;
        first_byte = entry.name_bytes[7:0];
        is_end     = (first_byte == MARK_END);
        is_skip    = (entry.entry_attributes == ATTR_LONG) || (first_byte == MARK_DELETED);
        is_match   = (count_eff == {8'd0, entry.wanted_index});

        count_next = count_reg;
        done_next  = done_reg;
        push       = 1'b0;

        if (accept)
        begin
            count_next = count_eff;
            done_next  = done_eff;
            if (!done_eff)
            begin
                if (is_end)
                begin
                    push      = 1'b1;
                    done_next = 1'b1;
                end
                else if (!is_skip)
                begin
                    if (is_match)
                    begin
                        push      = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (count_eff != COUNT_MAX)
                    begin
                        count_next = count_eff + 16'd1;
                    end
                end
            end
        end

        // End of directory carries fixed fields; a match carries the entry.
        push_job.is_end     = is_end;
        push_job.chars      = {entry.ext_bytes, entry.name_bytes};
        push_job.attributes = is_end ? 8'd0 : entry.entry_attributes;
        push_job.size       = is_end ? 32'd0 : entry.entry_size;
        push_job.cluster    = is_end ? END_CLUSTER : entry.entry_first_cluster;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ sv/fds_queue.sv @@
// ---------------------------------------------------------------------------
// fds_queue
// Short job queue between classifier and name emitter.
// ---------------------------------------------------------------------------
module fds_queue #(
    parameter int DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fds_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output fds_pkg::job_t head_job
);
    import fds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full       = (count_reg == CNT_FULL);
        head_valid = (count_reg != '0);
        head_job   = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

@@ sv/fds_back.sv @@
// ---------------------------------------------------------------------------
// fds_back
// Emit a formatted name or end marker, one character per cycle unless stalled.
// ---------------------------------------------------------------------------
module fds_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  fds_pkg::job_t      job,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output fds_pkg::scan_out_t result_data
);
    import fds_pkg::*;

    localparam int IDX_W = $clog2(NAME_LEN);
    localparam logic [IDX_W-1:0] EXT_FIRST = IDX_W'(BASE_LEN);

    logic                busy_reg;
    logic                busy_next;
    logic                is_end_reg;
    logic                is_end_next;
    name_chars_t         chars_reg;
    name_chars_t         chars_next;
    logic [7:0]          attr_reg;
    logic [7:0]          attr_next;
    logic [31:0]         size_reg;
    logic [31:0]         size_next;
    logic [15:0]         clus_reg;
    logic [15:0]         clus_next;
    logic [NAME_LEN-1:0] rem_reg;
    logic [NAME_LEN-1:0] rem_next;
    logic                dot_reg;
    logic                dot_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    scan_out_t           out_reg;
    scan_out_t           out_next;

    logic                advance;
    logic [IDX_W-1:0]    idx;
    logic [NAME_LEN-1:0] nonspace;

    always_comb
    begin
        for (int i = 0; i < NAME_LEN; i++)
        begin
            nonspace[i] = (job.chars[i] != CHAR_SPACE);
        end
        // Lowest remaining character position.
        idx = '0;
        for (int i = NAME_LEN - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        advance = !out_valid_reg || result_ready;
        pop     = !busy_reg && job_valid;

        busy_next      = busy_reg;
        is_end_next    = is_end_reg;
        chars_next     = chars_reg;
        attr_next      = attr_reg;
        size_next      = size_reg;
        clus_next      = clus_reg;
        rem_next       = rem_reg;
        dot_next       = dot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next   = 1'b1;
            is_end_next = job.is_end;
            chars_next  = job.chars;
            attr_next   = job.attributes;
            size_next   = job.size;
            clus_next   = job.cluster;
            rem_next    = job.is_end ? '0 : nonspace;
            dot_next    = !job.is_end && nonspace[BASE_LEN];
        end
        else if (busy_reg && advance)
        begin
            out_valid_next            = 1'b1;
            out_next.status           = is_end_reg ? STATUS_END : STATUS_CHAR;
            out_next.found_attributes = attr_reg;
            out_next.found_size       = size_reg;
            out_next.found_cluster    = clus_reg;
            out_next.last             = 1'b0;
            if (rem_reg == '0)
            begin
                // Terminator closes the run.
                out_next.name_char = CHAR_NUL;
                out_next.last      = 1'b1;
                busy_next          = 1'b0;
            end
            else if (idx == EXT_FIRST && dot_reg)
            begin
                out_next.name_char = CHAR_DOT;
                dot_next           = 1'b0;
            end
            else
            begin
                out_next.name_char = chars_reg[idx];
                rem_next[idx]      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_end_reg <= is_end_next;
        chars_reg  <= chars_next;
        attr_reg   <= attr_next;
        size_reg   <= size_next;
        clus_reg   <= clus_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            dot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rem_reg       <= rem_next;
            dot_reg       <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    a_end_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.status == STATUS_END) |->
            (result_data.last && result_data.name_char == CHAR_NUL))
        else $error("end-of-directory result not a lone terminator");

    a_dot_before_ext : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && dot_reg) |-> rem_reg[BASE_LEN])
        else $error("dot pending without extension character");

    a_load_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> busy_reg)
        else $error("job load did not start a run");

endmodule

@@ dv/fat_dir_entry_scanner_unit_tb.sv @@
// ---------------------------------------------------------------------------
// fat_dir_entry_scanner_unit_tb
// Self-checking bench for the FAT16 directory entry scanner. Directory
// entries go in over the entry channel with bursty timing, and the result
// channel is stalled on its own pattern. A scoreboard works out the
// formatted-name run or end marker that each entry causes and checks every
// result against it in order.
// ---------------------------------------------------------------------------
module fat_dir_entry_scanner_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fds_pkg::*;

    // Scoreboard: tracks the scan state, expands each accepted entry into the
    // characters it should produce, and checks results against that list.
    class dir_scan_scoreboard;
        bit [15:0]  entries_counted;
        bit         search_done;
        scan_out_t  expected_chars[$];
        int         errors;

        function void push_char(logic status, logic [7:0] ch, logic [7:0] attr,
                                logic [31:0] size, logic [15:0] clus, logic fin);
            scan_out_t r;
            r.status           = status;
            r.name_char        = ch;
            r.found_attributes = attr;
            r.found_size       = size;
            r.found_cluster    = clus;
            r.last             = fin;
            expected_chars.push_back(r);
        endfunction

        function void note_entry(scan_in_t e);
            logic [7:0] first;
            logic [7:0] c;
            int         b;
            first = e.name_bytes[7:0];
            if (e.start_scan) begin
                entries_counted = '0;
                search_done     = 1'b0;
            end
            if (search_done)
                return;
            if (first == MARK_END) begin
                push_char(STATUS_END, CHAR_NUL, 8'h00, 32'h0, END_CLUSTER, 1'b1);
                search_done = 1'b1;
                return;
            end
            if (e.entry_attributes == ATTR_LONG || first == MARK_DELETED)
                return;
            if (entries_counted != {8'h00, e.wanted_index}) begin
                if (entries_counted != COUNT_MAX)
                    entries_counted++;
                return;
            end
            for (b = 0; b < NAME_LEN; b++) begin
                c = (b < BASE_LEN) ? e.name_bytes[8*b +: 8] : e.ext_bytes[8*(b-BASE_LEN) +: 8];
                if (c != CHAR_SPACE) begin
                    if (b == BASE_LEN)
                        push_char(STATUS_CHAR, CHAR_DOT, e.entry_attributes,
                                  e.entry_size, e.entry_first_cluster, 1'b0);
                    push_char(STATUS_CHAR, c, e.entry_attributes,
                              e.entry_size, e.entry_first_cluster, 1'b0);
                end
            end
            push_char(STATUS_CHAR, CHAR_NUL, e.entry_attributes,
                      e.entry_size, e.entry_first_cluster, 1'b1);
            search_done = 1'b1;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(scan_out_t got);
            scan_out_t want;
            if (expected_chars.size() == 0) begin
                $error("result: none expected, got 0x%0h", got);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("name_char", 32'(want.name_char), 32'(got.name_char));
            compare_field("found_attributes", 32'(want.found_attributes),
                          32'(got.found_attributes));
            compare_field("found_size", want.found_size, got.found_size);
            compare_field("found_cluster", 32'(want.found_cluster),
                          32'(got.found_cluster));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    // Kinds of directory entry the generator can build.
    typedef enum int {
        KIND_SHORT,
        KIND_LONG,
        KIND_DELETED,
        KIND_END,
        KIND_NOISE
    } entry_kind_e;

    // Receiver stall styles; each runs for a random stretch of cycles.
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKED
    } rx_mode_e;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       entry_valid  = 1'b0;
    logic       entry_ready;
    scan_in_t   entry_data   = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    scan_out_t  result_data;

    dir_scan_scoreboard sb = new;

    int         burst_left = 0;
    int         sent_items = 0;
    rx_mode_e   rx_mode    = RX_STEADY;
    int         rx_left    = 0;

    fat_dir_entry_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_ready  (entry_ready),
        .entry_data   (entry_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #10 clk = ~clk;

    // Monitor: note the accepted request first, then check any result taken
    // at the same edge. Both handshakes are sampled before the edge's updates.
    always @(posedge clk) begin
        if (rst_n) begin
            if (entry_valid && entry_ready)
                sb.note_entry(entry_data);
            if (result_valid && result_ready)
                sb.check_result(result_data);
        end
    end

    // Receiver: pick a stall style for a random stretch, then drive ready at
    // the falling edge according to it. Blocked mode raises ready only when
    // rx_left is a multiple of 16; steady mode gives stretches with no stall at all.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_STEADY:  result_ready = 1'b1;
            RX_COIN:    result_ready = 1'($urandom_range(0, 1));
            RX_SPARSE:  result_ready = ($urandom_range(0, 7) == 0);
            default:    result_ready = (rx_left % 16 == 0);
        endcase
    end

    // Pack up to eight characters, byte 0 in the low bits, padded with spaces.
    function automatic logic [63:0] pack_text(string s);
        logic [63:0] v;
        int          k;
        for (k = 0; k < 8; k++)
            v[8*k +: 8] = (k < s.len()) ? s[k] : CHAR_SPACE;
        return v;
    endfunction

    function automatic scan_in_t entry_of(logic start, logic [7:0] wanted,
                                          logic [63:0] name, logic [23:0] ext,
                                          logic [7:0] attr, logic [15:0] clus,
                                          logic [31:0] size);
        scan_in_t e;
        e.start_scan          = start;
        e.wanted_index        = wanted;
        e.name_bytes          = name;
        e.ext_bytes           = ext;
        e.entry_attributes    = attr;
        e.entry_first_cluster = clus;
        e.entry_size          = size;
        return e;
    endfunction

    // Name bytes lean toward spaces, capitals and embedded zeros so the
    // space-dropping and dot rules get plenty of work.
    function automatic logic [7:0] pick_name_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CHAR_SPACE;
        else if (r < 33)
            return 8'h00;
        else if (r < 37)
            return MARK_DELETED;
        else if (r < 75)
            return 8'(8'h41 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic scan_in_t make_entry(entry_kind_e kind, logic start,
                                            logic [7:0] wanted);
        scan_in_t e;
        int       k;
        e.start_scan          = start;
        e.wanted_index        = wanted;
        e.entry_attributes    = 8'($urandom_range(0, 255));
        e.entry_first_cluster = 16'($urandom);
        e.entry_size          = $urandom;
        for (k = 0; k < 8; k++)
            e.name_bytes[8*k +: 8] = pick_name_byte();
        for (k = 0; k < 3; k++)
            e.ext_bytes[8*k +: 8] = pick_name_byte();
        case (kind)
            KIND_SHORT: begin
                if (e.name_bytes[7:0] == MARK_END || e.name_bytes[7:0] == MARK_DELETED)
                    e.name_bytes[7:0] = 8'(8'h41 + $urandom_range(0, 25));
                if (e.entry_attributes == ATTR_LONG)
                    e.entry_attributes = 8'h20;
            end
            KIND_LONG: begin
                e.entry_attributes = ATTR_LONG;
                if (e.name_bytes[7:0] == MARK_END)
                    e.name_bytes[7:0] = 8'h41;
            end
            KIND_DELETED: e.name_bytes[7:0] = MARK_DELETED;
            KIND_END:     e.name_bytes[7:0] = MARK_END;
            default: begin
                // Noise: everything random, including the start flag.
                e.name_bytes = {$urandom, $urandom};
                e.ext_bytes  = 24'($urandom);
                e.start_scan = ($urandom_range(0, 3) == 0);
            end
        endcase
        return e;
    endfunction

    // Present one request and hold it until taken. Called at a falling edge
    // and returns at one. Unless steady, close bursts with a random gap.
    task automatic send_entry(input scan_in_t e, input bit steady);
        int gap;
        entry_data  = e;
        entry_valid = 1'b1;
        @(posedge clk);
        while (!entry_ready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
        if (!steady) begin
            if (burst_left == 0) begin
                entry_valid = 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    // One search: a start entry, then a mix of short, long-name, deleted and
    // occasional end entries until the wanted entry has passed or the
    // directory ends, then up to two trailing entries that must be ignored.
    task automatic run_search();
        entry_kind_e kind;
        logic [7:0]  wanted;
        int          shorts;
        int          idx;
        int          r;
        bit          ended;
        r = $urandom_range(0, 9);
        wanted = (r < 7) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(5, 14));
        shorts = 0;
        idx    = 0;
        ended  = 1'b0;
        while (shorts <= wanted && !ended) begin
            r = $urandom_range(0, 99);
            kind = (r < 77) ? KIND_SHORT : (r < 87) ? KIND_LONG :
                   (r < 97) ? KIND_DELETED : KIND_END;
            send_entry(make_entry(kind, idx == 0, wanted), 1'b0);
            if (kind == KIND_SHORT)
                shorts++;
            if (kind == KIND_END)
                ended = 1'b1;
            idx++;
        end
        repeat ($urandom_range(0, 2))
            send_entry(make_entry(entry_kind_e'($urandom_range(0, 3)), 1'b0, wanted), 1'b0);
    endtask

    task automatic run_directed();
        // Plain 8.3 name with a dot, then an entry after done that is dropped.
        send_entry(entry_of(1'b1, 8'd0, pack_text("README"), 24'(pack_text("TXT")),
                            8'h20, 16'd2, 32'd1234), 1'b0);
        send_entry(entry_of(1'b0, 8'd0, pack_text("IGNORED"), 24'(pack_text("BIN")),
                            8'h20, 16'd3, 32'd1), 1'b0);
        // Long-name and deleted entries are skipped, two short ones counted,
        // then a full eleven-byte name of 0xFF with every other field at max.
        send_entry(entry_of(1'b1, 8'd2, pack_text("LFN"), 24'(pack_text("")),
                            ATTR_LONG, 16'd0, 32'd0), 1'b0);
        send_entry(entry_of(1'b0, 8'd2, 64'h2020_2045_4E4F_47E5,
                            24'(pack_text("TMP")), 8'h20, 16'd9, 32'd9), 1'b0);
        send_entry(entry_of(1'b0, 8'd2, pack_text("A"), 24'(pack_text("")),
                            8'h00, 16'd0, 32'd0), 1'b0);
        send_entry(entry_of(1'b0, 8'd7, pack_text("B"), 24'(pack_text("C")),
                            8'h10, 16'd5, 32'd5), 1'b0);
        send_entry(entry_of(1'b0, 8'd2, '1, '1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
        // Zero bytes inside the name are emitted; a space in extension byte 0
        // means no dot.
        send_entry(entry_of(1'b1, 8'd0, 64'h2020_2020_4200_0041, 24'h205820,
                            8'h00, 16'h0000, 32'h0), 1'b0);
        // End of directory wins over the long-name skip.
        send_entry(entry_of(1'b1, 8'd0, 64'h4141_4141_4141_4100, 24'h414141,
                            ATTR_LONG, 16'h7777, 32'h7777), 1'b0);
        send_entry(entry_of(1'b0, 8'd0, pack_text("AFTER"), 24'(pack_text("END")),
                            8'h20, 16'd1, 32'd1), 1'b0);
        // Deleted and long-name at once, then a count, then a match at one.
        send_entry(entry_of(1'b1, 8'd1, 64'h2020_2048_544F_42E5,
                            24'(pack_text("")), ATTR_LONG, 16'd0, 32'd0), 1'b0);
        send_entry(entry_of(1'b0, 8'd1, pack_text("ONE"), 24'(pack_text("C")),
                            8'h08, 16'd10, 32'd10), 1'b0);
        send_entry(entry_of(1'b0, 8'd1, pack_text("TWO"), 24'(pack_text("C")),
                            8'h04, 16'h8000, 32'h8000_0000), 1'b0);
        // Immediate end right after a start.
        send_entry(entry_of(1'b1, 8'd3, 64'h0, 24'h0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
        // Extension with only its last byte set: no dot.
        send_entry(entry_of(1'b1, 8'd0, pack_text("X"), 24'h5A2020,
                            8'h02, 16'h00FF, 32'h0000_FFFF), 1'b0);
        // High bit patterns and a 0x05 lead byte, wanted index at its top.
        send_entry(entry_of(1'b1, 8'hFF, 64'h8080_8080_8080_8005, 24'h808080,
                            8'h80, 16'hAAAA, 32'hAAAA_AAAA), 1'b0);
        send_entry(entry_of(1'b0, 8'h01, 64'h7F7F_7F7F_7F7F_7F05, 24'h7F7F7F,
                            8'h7F, 16'h5555, 32'h5555_5555), 1'b0);
        send_entry(entry_of(1'b0, 8'h00, pack_text("AFTER"), 24'(pack_text("TWO")),
                            8'h20, 16'd1, 32'd1), 1'b0);
    endtask

    initial begin
        int n;
        // Hold reset low, then release it at a falling edge.
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        // Random part: mostly well-formed searches, some noise entries.
        while (sent_items < 330) begin
            if ($urandom_range(0, 99) < 85) begin
                run_search();
            end else begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_entry(make_entry(KIND_NOISE, 1'b0, 8'($urandom_range(0, 255))), 1'b0);
            end
        end
        entry_valid = 1'b0;

        // Drain: wait for every expected character, then watch a little
        // longer for anything extra.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS fat_dir_entry_scanner_unit");
        else
            $display("FAIL fat_dir_entry_scanner_unit");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAIL fat_dir_entry_scanner_unit");
        $finish;
    end

endmodule

@@ files.f @@
sv/fds_pkg.sv
sv/fds_front.sv
sv/fds_queue.sv
sv/fds_back.sv
sv/fat_dir_entry_scanner_unit.sv
dv/fat_dir_entry_scanner_unit_tb.sv
